[rtl/core/dpt_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpt_pkg: shared types and constants of the door position tracker
// Position codes, configuration indexes and reset values, the tracker state
// record and the result record.
// ----------------------------------------------------------------------------
package dpt_pkg;

  typedef logic [1:0] pos_t;

  localparam pos_t POS_UNKNOWN = 2'd0;
  localparam pos_t POS_OPEN    = 2'd1;
  localparam pos_t POS_CLOSED  = 2'd2;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_TICKS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HOLD_TICKS    = 1'd1;

  localparam logic [7:0] TIMEOUT_TICKS_RST = 8'd20;
  localparam logic [7:0] HOLD_TICKS_RST    = 8'd3;
  localparam logic [7:0] COUNT_MAX         = 8'hFF;

  localparam logic MODE_TICK   = 1'b0;
  localparam logic MODE_TOGGLE = 1'b1;

  typedef struct packed {
    pos_t       last_position;
    pos_t       goal_position;
    logic       in_motion;
    logic       closed_reported;
    logic       timer_armed;
    logic [7:0] timer_count;
    logic [7:0] hold_count;
    logic       outcome_reported;
    logic       failed_flag;
    logic       skip_next_tick;
  } trk_state_t;

  localparam trk_state_t TRK_STATE_RST = '{
    last_position:    POS_UNKNOWN,
    goal_position:    POS_UNKNOWN,
    in_motion:        1'b0,
    closed_reported:  1'b0,
    timer_armed:      1'b0,
    timer_count:      8'd0,
    hold_count:       8'd0,
    outcome_reported: 1'b0,
    failed_flag:      1'b0,
    skip_next_tick:   1'b0
  };

  typedef struct packed {
    pos_t       known_position;
    pos_t       target_position;
    logic       moving;
    logic       shown_closed;
    logic       sensor_fault;
    logic       reached_event;
    logic       failed_event;
    logic       reach_failed;
    logic       stopped_mid_event;
    logic [7:0] ticks_left;
    logic       timeout_running;
  } trk_result_t;

  typedef struct packed {
    logic mode;
    logic open_sensor;
    logic closed_sensor;
  } trk_req_t;

endpackage

[rtl/core/door_position_tracker_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// door_position_tracker_core: door position tracker, top level
// Follows a door from open/closed end sensors and relay-toggle requests,
// tracking known and target position, hold and timeout counters, and
// giving one result per request.
// ----------------------------------------------------------------------------
//
//   channel | ports                          | direction | handshake
//   --------+--------------------------------+-----------+------------------
//   in      | in_mode, in_*_sensor           | to core   | in_valid/in_stall
//   out     | out_* result fields            | from core | out_valid/out_stall
//   cfg     | cfg_we, cfg_index, cfg_data    | to core   | write on cfg_we
//
// - Two register stages: request register, then result register. A request
//   passes through both before it is presented on the out side; one request
//   per cycle sustained while the out side does not stall.
// - The tracker state is updated as a request moves from the request
//   register into the result register, by the single-pass logic in
//   dpt_update.
// - A stall on the out side holds the result; the request register still
//   takes one more request, so in_stall rises only with both stages full.
// - Synchronous active-low reset clears the valid flags, the tracker state
//   and restores timeout_ticks to 20 and hold_ticks to 3.
// ----------------------------------------------------------------------------
module door_position_tracker_core
  import dpt_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,

  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,

  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  in_mode,
  input  logic                  in_open_sensor,
  input  logic                  in_closed_sensor,

  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [1:0]            out_known_position,
  output logic [1:0]            out_target_position,
  output logic                  out_moving,
  output logic                  out_shown_closed,
  output logic                  out_sensor_fault,
  output logic                  out_reached_event,
  output logic                  out_failed_event,
  output logic                  out_reach_failed,
  output logic                  out_stopped_mid_event,
  output logic [7:0]            out_ticks_left,
  output logic                  out_timeout_running
);

  // configuration registers
  logic [7:0] timeout_ticks_r;
  logic [7:0] hold_ticks_r;

  // request register
  logic     req_valid_r;
  trk_req_t req_r;

  // result register
  logic        res_valid_r;
  trk_result_t res_r;

  // tracker state
  trk_state_t  state_r;
  trk_state_t  state_nxt;
  trk_result_t res_nxt;

  logic res_free;   // result register can take a new result
  logic advance;    // request moves into the result stage
  logic in_take;    // request accepted on the in side

  assign res_free = !res_valid_r || !out_stall;
  assign advance  = req_valid_r && res_free;
  assign in_stall = req_valid_r && !res_free;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_ticks_r <= TIMEOUT_TICKS_RST;
      hold_ticks_r    <= HOLD_TICKS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_TIMEOUT_TICKS: timeout_ticks_r <= cfg_data;
        CFG_HOLD_TICKS:    hold_ticks_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  // request stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_valid_r <= 1'b0;
    end else if (in_take) begin
      req_valid_r <= 1'b1;
    end else if (advance) begin
      req_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      req_r.mode          <= in_mode;
      req_r.open_sensor   <= in_open_sensor;
      req_r.closed_sensor <= in_closed_sensor;
    end
  end

  dpt_update u_update (
    .req           (req_r),
    .cur           (state_r),
    .timeout_ticks (timeout_ticks_r),
    .hold_ticks    (hold_ticks_r),
    .nxt           (state_nxt),
    .res           (res_nxt)
  );

  // tracker state commits only when the request leaves the first stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= TRK_STATE_RST;
    end else if (advance) begin
      state_r <= state_nxt;
    end
  end

  // result stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_valid_r <= 1'b0;
    end else if (res_free) begin
      res_valid_r <= req_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid             = res_valid_r;
  assign out_known_position    = res_r.known_position;
  assign out_target_position   = res_r.target_position;
  assign out_moving            = res_r.moving;
  assign out_shown_closed      = res_r.shown_closed;
  assign out_sensor_fault      = res_r.sensor_fault;
  assign out_reached_event     = res_r.reached_event;
  assign out_failed_event      = res_r.failed_event;
  assign out_reach_failed      = res_r.reach_failed;
  assign out_stopped_mid_event = res_r.stopped_mid_event;
  assign out_ticks_left        = res_r.ticks_left;
  assign out_timeout_running   = res_r.timeout_running;

endmodule

[rtl/core/dpt_update.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpt_update: next-state and result logic of the door position tracker
// One request in, the next tracker state and its result out, all
// combinational.
// ----------------------------------------------------------------------------
module dpt_update
  import dpt_pkg::*;
(
  input  trk_req_t    req,
  input  trk_state_t  cur,
  input  logic [7:0]  timeout_ticks,
  input  logic [7:0]  hold_ticks,
  output trk_state_t  nxt,
  output trk_result_t res
);

  logic fault;
  logic reached;
  logic failed_ev;
  logic stopped;

  always_comb begin
    nxt       = cur;
    fault     = 1'b0;
    reached   = 1'b0;
    failed_ev = 1'b0;
    stopped   = 1'b0;

    if (req.mode == MODE_TOGGLE) begin
      nxt.timer_count      = timeout_ticks;
      nxt.timer_armed      = 1'b1;
      nxt.failed_flag      = 1'b0;
      nxt.skip_next_tick   = 1'b1;
      nxt.hold_count       = 8'd0;
      nxt.outcome_reported = 1'b0;
      if (cur.in_motion) begin
        // reversal while travelling
        stopped = 1'b1;
        if (cur.goal_position == POS_CLOSED) begin
          nxt.goal_position = POS_OPEN;
        end else if (cur.goal_position == POS_OPEN) begin
          nxt.goal_position = POS_CLOSED;
        end
      end else if (cur.last_position == POS_CLOSED) begin
        nxt.goal_position = POS_OPEN;
      end else if (cur.last_position == POS_OPEN) begin
        nxt.goal_position = POS_CLOSED;
      end
    end else begin
      if (!cur.skip_next_tick) begin
        // sensor sample
        nxt.in_motion       = 1'b0;
        nxt.closed_reported = 1'b0;
        if (req.open_sensor && req.closed_sensor) begin
          fault             = 1'b1;
          nxt.last_position = POS_UNKNOWN;
        end else if (req.open_sensor) begin
          nxt.last_position = POS_OPEN;
        end else if (req.closed_sensor) begin
          nxt.last_position   = POS_CLOSED;
          nxt.closed_reported = 1'b1;
        end else begin
          nxt.in_motion = 1'b1;
        end
        if (!nxt.in_motion && (cur.goal_position == POS_UNKNOWN)) begin
          nxt.goal_position = nxt.last_position;
        end

        // hold / timeout bookkeeping
        if ((nxt.goal_position == nxt.last_position) && !nxt.in_motion) begin
          if (cur.hold_count > hold_ticks) begin
            nxt.timer_armed = 1'b0;
            nxt.timer_count = 8'd0;
            nxt.failed_flag = 1'b0;
            if (!cur.outcome_reported) begin
              nxt.outcome_reported = 1'b1;
              reached              = 1'b1;
            end
          end else if (cur.hold_count != COUNT_MAX) begin
            nxt.hold_count = cur.hold_count + 8'd1;
          end
        end else if (cur.timer_armed && (cur.timer_count != 8'd0)) begin
          nxt.timer_count      = cur.timer_count - 8'd1;
          nxt.hold_count       = 8'd0;
          nxt.outcome_reported = 1'b0;
        end

        if (nxt.timer_armed && (nxt.timer_count == 8'd0)) begin
          if (!nxt.outcome_reported) begin
            nxt.outcome_reported = 1'b1;
            failed_ev            = 1'b1;
          end
          nxt.failed_flag = 1'b1;
          nxt.hold_count  = 8'd0;
        end
      end
      nxt.skip_next_tick = 1'b0;
    end
  end

  always_comb begin
    res.known_position    = nxt.last_position;
    res.target_position   = nxt.goal_position;
    res.moving            = nxt.in_motion;
    res.shown_closed      = nxt.closed_reported;
    res.sensor_fault      = fault;
    res.reached_event     = reached;
    res.failed_event      = failed_ev;
    res.reach_failed      = nxt.failed_flag;
    res.stopped_mid_event = stopped;
    res.ticks_left        = nxt.timer_armed ? nxt.timer_count : 8'd0;
    res.timeout_running   = nxt.timer_armed;
  end

endmodule

[sim/door_result_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// door_result_checker: result checker for the door position tracker
// Follows the register writes and the accepted requests, keeps its own copy
// of the tracker state, predicts one result per request and compares each
// accepted result against the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module door_result_checker
  import dpt_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  logic                  in_mode,
  input  logic                  in_open_sensor,
  input  logic                  in_closed_sensor,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  logic [1:0]            out_known_position,
  input  logic [1:0]            out_target_position,
  input  logic                  out_moving,
  input  logic                  out_shown_closed,
  input  logic                  out_sensor_fault,
  input  logic                  out_reached_event,
  input  logic                  out_failed_event,
  input  logic                  out_reach_failed,
  input  logic                  out_stopped_mid_event,
  input  logic [7:0]            out_ticks_left,
  input  logic                  out_timeout_running,
  output int                    fail_count,
  output int                    outstanding
);

  // register copies
  logic [7:0] timeout_cfg;
  logic [7:0] hold_cfg;

  // tracker state copy
  pos_t       last_pos;
  pos_t       goal_pos;
  logic       in_motion;
  logic       closed_seen;
  logic       timer_on;
  logic [7:0] timer_cnt;
  logic [7:0] hold_cnt;
  logic       outcome_done;
  logic       fail_sticky;
  logic       skip_tick;

  trk_result_t expected_q[$];
  trk_result_t want;
  bit          bad;
  int          result_count = 0;

  function automatic trk_result_t advance_tracker(input logic mode, input logic op,
                                                  input logic cl);
    trk_result_t r;
    logic fault, reached, failed_now, stopped;
    fault      = 1'b0;
    reached    = 1'b0;
    failed_now = 1'b0;
    stopped    = 1'b0;
    if (mode == MODE_TOGGLE) begin
      timer_cnt    = timeout_cfg;
      timer_on     = 1'b1;
      fail_sticky  = 1'b0;
      skip_tick    = 1'b1;
      hold_cnt     = 8'd0;
      outcome_done = 1'b0;
      if (in_motion) begin
        stopped = 1'b1;
        if (goal_pos == POS_CLOSED) goal_pos = POS_OPEN;
        else if (goal_pos == POS_OPEN) goal_pos = POS_CLOSED;
      end else if (last_pos == POS_CLOSED) begin
        goal_pos = POS_OPEN;
      end else if (last_pos == POS_OPEN) begin
        goal_pos = POS_CLOSED;
      end
    end else begin
      if (!skip_tick) begin
        in_motion   = 1'b0;
        closed_seen = 1'b0;
        if (op && cl) begin
          fault    = 1'b1;
          last_pos = POS_UNKNOWN;
        end else if (op) begin
          last_pos = POS_OPEN;
        end else if (cl) begin
          last_pos    = POS_CLOSED;
          closed_seen = 1'b1;
        end else begin
          in_motion = 1'b1;
        end
        if (!in_motion && goal_pos == POS_UNKNOWN) goal_pos = last_pos;

        if (goal_pos == last_pos && !in_motion) begin
          if (hold_cnt > hold_cfg) begin
            timer_on    = 1'b0;
            timer_cnt   = 8'd0;
            fail_sticky = 1'b0;
            if (!outcome_done) begin
              outcome_done = 1'b1;
              reached      = 1'b1;
            end
          end else if (hold_cnt != COUNT_MAX) begin
            hold_cnt = hold_cnt + 8'd1;
          end
        end else if (timer_on && timer_cnt != 8'd0) begin
          timer_cnt    = timer_cnt - 8'd1;
          hold_cnt     = 8'd0;
          outcome_done = 1'b0;
        end

        // expired timeout stays armed at zero, failure pulsed once
        if (timer_on && timer_cnt == 8'd0) begin
          if (!outcome_done) begin
            outcome_done = 1'b1;
            failed_now   = 1'b1;
          end
          fail_sticky = 1'b1;
          hold_cnt    = 8'd0;
        end
      end
      skip_tick = 1'b0;
    end

    r.known_position    = last_pos;
    r.target_position   = goal_pos;
    r.moving            = in_motion;
    r.shown_closed      = closed_seen;
    r.sensor_fault      = fault;
    r.reached_event     = reached;
    r.failed_event      = failed_now;
    r.reach_failed      = fail_sticky;
    r.stopped_mid_event = stopped;
    r.ticks_left        = timer_on ? timer_cnt : 8'd0;
    r.timeout_running   = timer_on;
    return r;
  endfunction

  task automatic compare_field(input string field, input logic [7:0] exp_v,
                               input logic [7:0] got_v);
    if (got_v !== exp_v) begin
      if (!bad) begin
        bad = 1'b1;
        fail_count++;
      end
      if (fail_count <= 10)
        $display("result %0d %s: expected %0h, got %0h", result_count, field, exp_v, got_v);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      timeout_cfg  = TIMEOUT_TICKS_RST;
      hold_cfg     = HOLD_TICKS_RST;
      last_pos     = POS_UNKNOWN;
      goal_pos     = POS_UNKNOWN;
      in_motion    = 1'b0;
      closed_seen  = 1'b0;
      timer_on     = 1'b0;
      timer_cnt    = 8'd0;
      hold_cnt     = 8'd0;
      outcome_done = 1'b0;
      fail_sticky  = 1'b0;
      skip_tick    = 1'b0;
      expected_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_TIMEOUT_TICKS: timeout_cfg = cfg_data;
          CFG_HOLD_TICKS:    hold_cfg    = cfg_data;
          default: ;
        endcase
      end

      if (in_valid && !in_stall)
        expected_q.push_back(advance_tracker(in_mode, in_open_sensor, in_closed_sensor));

      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("result %0d arrived with no request outstanding", result_count);
        end else begin
          want = expected_q.pop_front();
          bad  = 1'b0;
          compare_field("known_position",    8'(want.known_position),
                        8'(out_known_position));
          compare_field("target_position",   8'(want.target_position),
                        8'(out_target_position));
          compare_field("moving",            8'(want.moving),            8'(out_moving));
          compare_field("shown_closed",      8'(want.shown_closed),      8'(out_shown_closed));
          compare_field("sensor_fault",      8'(want.sensor_fault),      8'(out_sensor_fault));
          compare_field("reached_event",     8'(want.reached_event),
                        8'(out_reached_event));
          compare_field("failed_event",      8'(want.failed_event),      8'(out_failed_event));
          compare_field("reach_failed",      8'(want.reach_failed),      8'(out_reach_failed));
          compare_field("stopped_mid_event", 8'(want.stopped_mid_event),
                        8'(out_stopped_mid_event));
          compare_field("ticks_left",        want.ticks_left,            out_ticks_left);
          compare_field("timeout_running",   8'(want.timeout_running),
                        8'(out_timeout_running));
        end
        result_count++;
      end
    end
    outstanding = expected_q.size();
  end

endmodule

[sim/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: top level of the door position tracker simulation
// Drives register settings and door requests into the core, applies random
// back-pressure on the result side and gives the verdict from the failure
// count of the result checker.
// ----------------------------------------------------------------------------
module testbench;
  import dpt_pkg::*;

  // longest run of cycles with no handshake at all before we give up;
  // sender gaps and result stalls stay well below this limit
  localparam int IDLE_LIMIT = 2000;

  logic                  clk              = 1'b0;
  logic                  rst_n            = 1'b0;
  logic                  cfg_we           = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index        = '0;
  logic [CFG_DATA_W-1:0] cfg_data         = '0;
  logic                  in_valid         = 1'b0;
  logic                  in_mode          = MODE_TICK;
  logic                  in_open_sensor   = 1'b0;
  logic                  in_closed_sensor = 1'b0;
  logic                  out_stall        = 1'b0;

  logic                  in_stall;
  logic                  out_valid;
  logic [1:0]            out_known_position;
  logic [1:0]            out_target_position;
  logic                  out_moving;
  logic                  out_shown_closed;
  logic                  out_sensor_fault;
  logic                  out_reached_event;
  logic                  out_failed_event;
  logic                  out_reach_failed;
  logic                  out_stopped_mid_event;
  logic [7:0]            out_ticks_left;
  logic                  out_timeout_running;

  int fail_count;
  int outstanding;

  // stimulus bookkeeping
  int   requests_sent = 0;
  int   timeout_now   = 32'(TIMEOUT_TICKS_RST);
  int   hold_now      = 32'(HOLD_TICKS_RST);
  bit   gapless       = 1'b0;
  pos_t door_end      = POS_CLOSED;   // where the simulated door physically sits

  // result-side stall pattern
  int stall_left = 0;
  int quiet_left = 0;
  int stall_roll;

  int idle_cycles = 0;

  always #5 clk = ~clk;

  door_position_tracker_core uut (.*);

  door_result_checker result_chk (.*);

  // Gap lengths: mostly none or short, now and then a long one.
  function automatic int gap_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Receiver back-pressure, with quiet stretches where it never stalls.
  always @(posedge clk) begin
    if (quiet_left > 0) begin
      quiet_left <= quiet_left - 1;
      out_stall  <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall  <= 1'b1;
    end else begin
      stall_roll = $urandom_range(0, 99);
      if (stall_roll < 2) begin
        quiet_left <= $urandom_range(30, 150);
        out_stall  <= 1'b0;
      end else if (stall_roll < 72) begin
        out_stall <= 1'b0;
      end else begin
        out_stall  <= 1'b1;
        stall_left <= gap_length();
      end
    end
  end

  // Watchdog: any handshake or register write counts as progress.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("[door_position_tracker_core] ERROR");
      $finish;
    end
  end

  // Present one request and hold it until the core takes it. Valid stays
  // high afterwards so back-to-back requests need no extra assignment.
  task automatic send_request(input logic mode, input logic op, input logic cl);
    in_valid         <= 1'b1;
    in_mode          <= mode;
    in_open_sensor   <= op;
    in_closed_sensor <= cl;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    requests_sent++;
  endtask

  task automatic sender_gap();
    int n;
    n = gapless ? 0 : gap_length();
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic send_gapped(input logic mode, input logic op, input logic cl);
    send_request(mode, op, cl);
    sender_gap();
  endtask

  // Sender holds off until every result is back, then lets the pipeline
  // (two stages) run dry before anything else happens.
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    wait (outstanding == 0);
    repeat (4) @(posedge clk);
  endtask

  // Registers only change with the core idle; both are written every time.
  task automatic program_regs(input logic [7:0] t, input logic [7:0] h);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_TIMEOUT_TICKS;
    cfg_data  <= t;
    @(posedge clk);
    cfg_index <= CFG_HOLD_TICKS;
    cfg_data  <= h;
    @(posedge clk);
    cfg_we      <= 1'b0;
    timeout_now = 32'(t);
    hold_now    = 32'(h);
  endtask

  // One door operation: toggle, travel with neither sensor, maybe a second
  // toggle mid-travel, then sit at the far end for a while. A share of the
  // traffic is plain noise instead, including both sensors at once.
  task automatic door_operation();
    int   roll, travel, settle_ticks, n;
    pos_t dest;
    roll    = $urandom_range(0, 99);
    gapless = ($urandom_range(0, 3) == 0);
    if (roll < 15) begin
      n = $urandom_range(1, 4);
      repeat (n) send_gapped(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                             1'($urandom_range(0, 1)));
    end else begin
      dest = (door_end == POS_OPEN) ? POS_CLOSED : POS_OPEN;
      // sensor bits on a toggle are don't-care, so randomise them
      send_gapped(MODE_TOGGLE, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      travel = $urandom_range(0, (timeout_now + 2 < 30) ? timeout_now + 2 : 30);
      repeat (travel) send_gapped(MODE_TICK, 1'b0, 1'b0);
      if ($urandom_range(0, 4) == 0) begin
        // reverse mid-travel
        send_gapped(MODE_TOGGLE, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        dest = (dest == POS_OPEN) ? POS_CLOSED : POS_OPEN;
        repeat ($urandom_range(0, 5)) send_gapped(MODE_TICK, 1'b0, 1'b0);
      end
      settle_ticks = $urandom_range(1, (hold_now + 4 < 40) ? hold_now + 4 : 40);
      repeat (settle_ticks) begin
        if ($urandom_range(0, 9) == 0)
          send_gapped(MODE_TICK, 1'b1, 1'b1);  // sensor glitch
        else
          send_gapped(MODE_TICK, dest == POS_OPEN, dest == POS_CLOSED);
      end
      door_end = dest;
    end
  endtask

  task automatic run_phase(input int count);
    int stop_at;
    stop_at = requests_sent + count;
    while (requests_sent < stop_at) begin
      door_operation();
      if ($urandom_range(0, 99) == 0) drain_results();
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed opening at the reset settings (timeout 20, hold 3).
    // Toggle with unknown position: target must stay unknown.
    send_request(MODE_TOGGLE, 1'b1, 1'b1);
    // Tick straight after a toggle is skipped, sensors ignored.
    send_request(MODE_TICK, 1'b1, 1'b1);
    // Open sensor adopts open as target, then hold builds until reached.
    repeat (5) send_request(MODE_TICK, 1'b1, 1'b0);
    // Toggle at rest from open: target becomes closed.
    send_request(MODE_TOGGLE, 1'b0, 1'b0);
    send_request(MODE_TICK, 1'b0, 1'b1);
    send_request(MODE_TICK, 1'b0, 1'b0);
    // Toggle while moving: stopped-mid pulse and target reversed.
    send_request(MODE_TOGGLE, 1'b1, 1'b0);
    send_request(MODE_TICK, 1'b0, 1'b0);
    // Both sensors: fault, position unknown.
    send_request(MODE_TICK, 1'b1, 1'b1);
    send_request(MODE_TICK, 1'b0, 1'b1);
    send_request(MODE_TICK, 1'b0, 1'b0);
    door_end = POS_CLOSED;

    // Random traffic over several register settings, extremes included.
    run_phase(90);
    program_regs(8'd1, 8'd0);      // shortest nonzero timeout, arrival on second hold tick
    run_phase(100);
    program_regs(8'd0, 8'd255);    // timeout expires at once, arrival never declared
    run_phase(60);
    program_regs(8'd255, 8'd254);  // longest timeout, longest hold that still arrives
    run_phase(100);
    program_regs(8'd4, 8'd1);
    run_phase(100);
    repeat (3) begin
      program_regs(8'($urandom_range(1, 30)), 8'($urandom_range(0, 8)));
      run_phase(100);
    end

    drain_results();
    repeat (10) @(posedge clk);
    if (fail_count == 0 && outstanding == 0)
      $display("[door_position_tracker_core] OK");
    else
      $display("[door_position_tracker_core] ERROR");
    $finish;
  end

endmodule
